FILE: src/axis_max_argmax_reduction_defines.svh
// Assertion helpers for the max/argmax reduction.
`ifndef AXIS_MAX_ARGMAX_REDUCTION_DEFINES_SVH
`define AXIS_MAX_ARGMAX_REDUCTION_DEFINES_SVH

// same-cycle implication
`define AMAXR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AMAXR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/amaxr_pkg.sv
package amaxr_pkg;

	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int REDUCE_CFG_W = 13;
	localparam int INNER_CFG_W  = 11;

	localparam logic [CFG_IDX_W-1:0] REG_REDUCE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT  = 2'd1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] pos;
	} entry_t;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
	} flags_t;

endpackage

FILE: src/amaxr_seq.sv
module amaxr_seq #(
	parameter int REDUCE_MAX = 4096,
	parameter int INNER_MAX  = 1024,
	localparam int RIW = (REDUCE_MAX > 1) ? $clog2(REDUCE_MAX) : 1,
	localparam int CIW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [amaxr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [amaxr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                advance,
	output logic [RIW-1:0]                      row,
	output logic [CIW-1:0]                      col,
	output logic [RIW-1:0]                      rows_last,
	output logic [CIW-1:0]                      cols_last,
	output amaxr_pkg::flags_t                   flags
);

	logic [RIW-1:0] row_q;
	logic [CIW-1:0] col_q;
	logic [RIW-1:0] rows_last_q;
	logic [CIW-1:0] cols_last_q;
	logic [amaxr_pkg::REDUCE_CFG_W-1:0] reduce_req;
	logic [amaxr_pkg::INNER_CFG_W-1:0]  inner_req;
	logic [RIW-1:0] rows_last_d;
	logic [CIW-1:0] cols_last_d;

	assign reduce_req = cfg_data[amaxr_pkg::REDUCE_CFG_W-1:0];
	assign inner_req  = cfg_data[amaxr_pkg::INNER_CFG_W-1:0];

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (reduce_req == '0) begin
			rows_last_d = '0;
		end else if (32'(reduce_req) > 32'(REDUCE_MAX)) begin
			rows_last_d = RIW'(REDUCE_MAX - 1);
		end else begin
			rows_last_d = RIW'(reduce_req - 1'b1);
		end
		if (inner_req == '0) begin
			cols_last_d = '0;
		end else if (32'(inner_req) > 32'(INNER_MAX)) begin
			cols_last_d = CIW'(INNER_MAX - 1);
		end else begin
			cols_last_d = CIW'(inner_req - 1'b1);
		end
	end

	assign flags.first_row = (row_q == '0);
	assign flags.last_row  = (row_q == rows_last_q);
	assign flags.last_col  = (col_q == cols_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			rows_last_q <= '0;
			cols_last_q <= '0;
		end else if (cfg_we && (cfg_index == amaxr_pkg::REG_REDUCE_COUNT ||
				cfg_index == amaxr_pkg::REG_INNER_COUNT)) begin
			row_q <= '0;
			col_q <= '0;
			if (cfg_index == amaxr_pkg::REG_REDUCE_COUNT) begin
				rows_last_q <= rows_last_d;
			end else begin
				cols_last_q <= cols_last_d;
			end
		end else if (advance) begin
			if (flags.last_col) begin
				col_q <= '0;
				row_q <= flags.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign row       = row_q;
	assign col       = col_q;
	assign rows_last = rows_last_q;
	assign cols_last = cols_last_q;

endmodule

FILE: src/amaxr_colmem.sv
module amaxr_colmem #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output amaxr_pkg::entry_t     rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  amaxr_pkg::entry_t     wr_data
);

	amaxr_pkg::entry_t mem [DEPTH];
	amaxr_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/axis_max_argmax_reduction.sv
// Results: the item that closes a column passes s1, then the result register.
// Throughput: one item per cycle while not stalled; the column store does one
// read and one write per cycle, forwarding when a row holds a single column.
// Reset: row and column counters clear, both lengths return to 1, the column
// store is not cleared (row 0 of a block writes every column before use).
module axis_max_argmax_reduction #(
	parameter int INNER_MAX  = 1024,
	parameter int REDUCE_MAX = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [amaxr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [amaxr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [amaxr_pkg::VALUE_W-1:0] value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [amaxr_pkg::VALUE_W-1:0] max_value,
	output logic [amaxr_pkg::INDEX_W-1:0]       max_index,
	output logic                                last_of_block
);

	`include "axis_max_argmax_reduction_defines.svh"

	localparam int RIW = (REDUCE_MAX > 1) ? $clog2(REDUCE_MAX) : 1;
	localparam int CIW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;

	logic                 accept;
	logic [RIW-1:0]       row;
	logic [CIW-1:0]       col;
	logic [RIW-1:0]       rows_last;
	logic [CIW-1:0]       cols_last;
	amaxr_pkg::flags_t    flags;

	logic                 valid_s1;
	logic signed [amaxr_pkg::VALUE_W-1:0] value_s1;
	logic [RIW-1:0]       row_s1;
	logic [CIW-1:0]       col_s1;
	amaxr_pkg::flags_t    flags_s1;
	logic                 fwd_s1;
	amaxr_pkg::entry_t    fwd_data_s1;

	amaxr_pkg::entry_t    rd_data;
	amaxr_pkg::entry_t    best;
	amaxr_pkg::entry_t    upd;
	logic                 adv_s1;
	logic                 wr_en;

	logic                 result_valid_q;
	amaxr_pkg::entry_t    result_q;
	logic                 last_q;

	assign adv_s1     = !(result_valid_q && result_stall && flags_s1.last_row);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;
	assign wr_en      = valid_s1 && adv_s1;

	amaxr_seq #(
		.REDUCE_MAX (REDUCE_MAX),
		.INNER_MAX  (INNER_MAX)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.row       (row),
		.col       (col),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.flags     (flags)
	);

	amaxr_colmem #(
		.DEPTH (INNER_MAX)
	) u_colmem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (upd)
	);

	// strict greater keeps the first row on a tie
	always_comb begin
		best = fwd_s1 ? fwd_data_s1 : rd_data;
		if (flags_s1.first_row || (value_s1 > $signed(best.value))) begin
			upd.value = value_s1;
			upd.pos   = amaxr_pkg::INDEX_W'(row_s1);
		end else begin
			upd = best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en && flags_s1.last_row) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1    <= value;
			row_s1      <= row;
			col_s1      <= col;
			flags_s1    <= flags;
			fwd_s1      <= wr_en && (col == col_s1);
			fwd_data_s1 <= upd;
		end
		if (wr_en && flags_s1.last_row) begin
			result_q <= upd;
			last_q   <= flags_s1.last_col;
		end
	end

	assign result_valid  = result_valid_q;
	assign max_value     = $signed(result_q.value);
	assign max_index     = result_q.pos;
	assign last_of_block = last_q;

	`AMAXR_ASSERT_NOW(a_counter_bound, clk, arst_n, 1'b1,
		(row <= rows_last) && (col <= cols_last), "position counter past block length")
	`AMAXR_ASSERT_NEXT(a_row_wrap, clk, arst_n, accept && flags.last_col,
		col == '0, "column counter did not wrap after last column")
	`AMAXR_ASSERT_NOW(a_result_source, clk, arst_n, $rose(result_valid),
		$past(valid_s1 && flags_s1.last_row), "result without a closing item")

endmodule
